FILE: rtl/complex_magnitude_16_macros.svh
// Assertion macros for the complex magnitude block.
`ifndef COMPLEX_MAGNITUDE_16_MACROS_SVH
`define COMPLEX_MAGNITUDE_16_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CM_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define CM_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("assertion failed");
`else
`define CM_ASSERT_IMPL(label, clk, rst_n, prop)
`define CM_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif
`endif

FILE: rtl/cmag_pkg.sv
// Package: types and constants for the complex magnitude pipeline.
`timescale 1ns / 1ps
package cmag_pkg;
    localparam int unsigned SQ_W = 32;
    localparam int unsigned EST_W = 16;
    localparam logic [14:0] INV_SQRT2_Q15 = 15'd23170;
    localparam int unsigned EST_SHIFT = 15;
    localparam logic [EST_W-1:0] EST_MAX = 16'd32767;

    typedef struct packed {
        logic [SQ_W-1:0]  square;
        logic [EST_W-1:0] est;
    } cmag_work_t;
endpackage

FILE: rtl/cmag_front.sv
// Front end: absolute values, sum of squares and first estimate, four stages.
`timescale 1ns / 1ps
module cmag_front
    import cmag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [15:0] real_part,
    input  logic [15:0] imag_part,
    output logic        out_valid,
    output cmag_work_t  out_work
);
    logic [3:0]  valid_reg;
    logic [16:0] a_reg, b_reg;
    logic [31:0] sa_reg, sb_reg;
    logic [17:0] ab_reg;
    logic [31:0] square_reg;
    logic [32:0] prod_reg;
    cmag_work_t  work_reg;
    logic [16:0] a_next, b_next;
    logic [17:0] first;

    assign a_next = real_part[15] ? (17'h10000 - {1'b0, real_part}) : {1'b0, real_part};
    assign b_next = imag_part[15] ? (17'h10000 - {1'b0, imag_part}) : {1'b0, imag_part};
    assign first  = prod_reg[32:15];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            sa_reg     <= 32'(a_reg * a_reg);
            sb_reg     <= 32'(b_reg * b_reg);
            ab_reg     <= {1'b0, a_reg} + {1'b0, b_reg};
            square_reg <= sa_reg + sb_reg;
            prod_reg   <= 33'(ab_reg * INV_SQRT2_Q15);
            work_reg.square <= square_reg;
            work_reg.est    <= (first > 18'(EST_MAX)) ? EST_MAX : first[EST_W-1:0];
        end
    end

    assign out_valid = valid_reg[3];
    assign out_work  = work_reg;
endmodule

FILE: rtl/cmag_newton.sv
// One Newton step: pipelined restoring divide (four quotient bits per stage), then average.
`timescale 1ns / 1ps
module cmag_newton
    import cmag_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  cmag_work_t in_work,
    output logic       out_valid,
    output cmag_work_t out_work
);
    localparam int unsigned STAGES = SQ_W / 4;

    logic [STAGES-1:0] valid_reg;
    logic [SQ_W-1:0]   sq_reg   [STAGES];
    logic [EST_W-1:0]  est_reg  [STAGES];
    logic [EST_W:0]    rem_reg  [STAGES];
    logic [SQ_W-1:0]   quot_reg [STAGES];
    logic [SQ_W-1:0]   dvd_reg  [STAGES];
    logic [EST_W:0]    rem_next  [STAGES];
    logic [SQ_W-1:0]   quot_next [STAGES];
    logic [SQ_W-1:0]   dvd_next  [STAGES];
    cmag_work_t        work_reg;
    logic              vout_reg;
    logic [SQ_W:0]     sum;

    always_comb
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            logic [EST_W:0]   r;
            logic [SQ_W-1:0]  q;
            logic [SQ_W-1:0]  d;
            logic [EST_W-1:0] dv;
            if (s == 0)
            begin
                r  = '0;
                q  = '0;
                d  = in_work.square;
                dv = in_work.est;
            end
            else
            begin
                r  = rem_reg[s-1];
                q  = quot_reg[s-1];
                d  = dvd_reg[s-1];
                dv = est_reg[s-1];
            end
            for (int k = 0; k < 4; k++)
            begin
                r = {r[EST_W-1:0], d[SQ_W-1]};
                d = {d[SQ_W-2:0], 1'b0};
                if (r >= {1'b0, dv})
                begin
                    r = r - {1'b0, dv};
                    q = {q[SQ_W-2:0], 1'b1};
                end
                else
                begin
                    q = {q[SQ_W-2:0], 1'b0};
                end
            end
            rem_next[s]  = r;
            quot_next[s] = q;
            dvd_next[s]  = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vout_reg  <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
            vout_reg  <= valid_reg[STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
                dvd_reg[s]  <= dvd_next[s];
            end
            sq_reg[0]  <= in_work.square;
            est_reg[0] <= in_work.est;
            for (int s = 1; s < STAGES; s++)
            begin
                sq_reg[s]  <= sq_reg[s-1];
                est_reg[s] <= est_reg[s-1];
            end
            work_reg.square <= sq_reg[STAGES-1];
            work_reg.est    <= (est_reg[STAGES-1] == '0) ? '0 : sum[EST_W:1];
        end
    end

    assign sum       = {1'b0, quot_reg[STAGES-1]} + (SQ_W+1)'(est_reg[STAGES-1]);
    assign out_valid = vout_reg;
    assign out_work  = work_reg;
endmodule

FILE: rtl/complex_magnitude_16.sv
// Complex magnitude top level: front end, Newton chain and output skid.
// Throughput: one transfer per cycle; the pipeline holds while output stalls.
// Each Newton step is an 8-stage radix-16 divider plus one averaging stage.
// A zero estimate stays zero through later steps and gives magnitude 0.
// rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps
`include "complex_magnitude_16_macros.svh"
module complex_magnitude_16
    import cmag_pkg::*;
#(
    parameter int NEWTON_STEPS = 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] real_part, [31:16] imag_part
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [15:0] magnitude
);
    logic       en;
    logic       v [NEWTON_STEPS+1];
    cmag_work_t w [NEWTON_STEPS+1];
    logic       out_valid_reg;
    logic [15:0] out_data_reg;

    assign en = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    cmag_front u_front (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid),
        .real_part(s_axis_tdata[15:0]), .imag_part(s_axis_tdata[31:16]),
        .out_valid(v[0]), .out_work(w[0])
    );

    for (genvar g = 0; g < NEWTON_STEPS; g++)
    begin : g_step
        cmag_newton u_step (
            .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v[g]), .in_work(w[g]),
            .out_valid(v[g+1]), .out_work(w[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v[NEWTON_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= w[NEWTON_STEPS].est;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `CM_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `CM_ASSERT_IMPL(a_ready_free, clk, rst_n, !m_axis_tvalid |-> s_axis_tready)
    `CM_ASSERT_NEXT(a_stall_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
endmodule

FILE: tb/sv/tb_complex_magnitude_16.sv
// Testbench for complex_magnitude_16: random and directed samples checked against a predictor.
`timescale 1ns / 1ps
module tb_complex_magnitude_16;
    import cmag_pkg::*;

    localparam int STEPS = 3;
    localparam int LATENCY = 4 + 9 * STEPS;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    class magnitude_scoreboard;
        logic [15:0] pending_mag[$];
        int errors;

        function logic [16:0] abs_part(logic [15:0] raw);
            logic [16:0] v;
            v = {1'b0, raw};
            if (raw[15])
                v = 17'h10000 - v;
            return v;
        endfunction

        function logic [15:0] predict_magnitude(logic [15:0] re, logic [15:0] im);
            logic [31:0] a;
            logic [31:0] b;
            logic [31:0] square;
            logic [63:0] first;
            logic [31:0] est;
            logic [31:0] quot;
            logic [32:0] total;
            a = {15'd0, abs_part(re)};
            b = {15'd0, abs_part(im)};
            square = a * a + b * b;
            first = (64'(a + b) * 64'd23170) >> 15;
            if (first > 64'd32767)
                first = 64'd32767;
            est = first[31:0];
            for (int i = 0; i < STEPS; i++)
            begin
                if (est == 0)
                    return 16'd0;
                quot = square / est;
                total = {1'b0, est} + {1'b0, quot};
                est = {16'd0, total[16:1]};
            end
            return est[15:0];
        endfunction

        function void note_sample(logic [31:0] data);
            pending_mag.push_back(predict_magnitude(data[15:0], data[31:16]));
        endfunction

        function void check_magnitude(logic [15:0] got);
            logic [15:0] want;
            if (pending_mag.size() == 0)
            begin
                $display("%0t: unexpected magnitude %0d", $time, got);
                errors++;
                return;
            end
            want = pending_mag.pop_front();
            if (want !== got)
            begin
                $display("%0t: magnitude expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    magnitude_scoreboard board;
    logic [31:0] samples[$];
    longint cycles;
    bit stall_mode;

    complex_magnitude_16 #(.NEWTON_STEPS(STEPS)) uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_complex_magnitude_16 failed");
                $finish;
            end
        end
    end

    // receiver: stall pattern alternates between free-running and random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_magnitude(m_axis_tdata);
            if (($urandom_range(0, 63)) == 0)
                stall_mode = ~stall_mode;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    task automatic send_sample(logic [31:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_sample(data);
    endtask

    task automatic drive_all();
        int burst;
        int gap;
        while (samples.size() > 0)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && samples.size() > 0)
            begin
                send_sample(samples.pop_front());
                burst--;
            end
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending_mag.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] edge_vals[$];
        logic [15:0] r;
        logic [15:0] q;
        board = new();
        stall_mode = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        edge_vals = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0002};
        foreach (edge_vals[i])
            foreach (edge_vals[j])
                if (samples.size() < 25)
                    samples.push_back({edge_vals[j], edge_vals[i]});
        drive_all();
        wait_drained();

        for (int k = 0; k < N_RANDOM; k++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    r = 16'($urandom_range(0, 7) - 3);
                    q = 16'($urandom_range(0, 7) - 3);
                end
                1:
                begin
                    r = 16'($urandom);
                    q = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                end
                default:
                begin
                    r = 16'($urandom);
                    q = 16'($urandom);
                end
            endcase
            samples.push_back({q, r});
            if (k == N_RANDOM / 2)
            begin
                drive_all();
                wait_drained();
            end
        end
        drive_all();
        wait_drained();

        if (board.errors == 0 && board.pending_mag.size() == 0)
            $display("tb_complex_magnitude_16 passed");
        else
            $display("tb_complex_magnitude_16 failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/cmag_pkg.sv
rtl/cmag_front.sv
rtl/cmag_newton.sv
rtl/complex_magnitude_16.sv
tb/sv/tb_complex_magnitude_16.sv
